/* hw/rtl/mie_pkg.sv */
`default_nettype none
package mie_pkg;

    localparam int DataWidthDefault = 64;
    localparam int FieldWidth = 63;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_MUL,
        ST_UPDATE,
        ST_FIX,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic mul_step;
        logic update;
        logic fix;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic rem_zero;
        logic div_last;
    } dp_status_t;

endpackage
`default_nettype wire

/* hw/rtl/mie_if.sv */
`default_nettype none
interface mie_in_if;
    logic valid;
    logic ready;
    logic [mie_pkg::FieldWidth-1:0] value;
    logic [mie_pkg::FieldWidth-1:0] modulus;
    modport source (output valid, value, modulus, input ready);
    modport sink (input valid, value, modulus, output ready);
endinterface

interface mie_out_if;
    logic valid;
    logic ready;
    logic [mie_pkg::FieldWidth-1:0] inverse;
    logic [mie_pkg::FieldWidth-1:0] common_divisor;
    logic invertible;
    modport source (output valid, inverse, common_divisor, invertible, input ready);
    modport sink (input valid, inverse, common_divisor, invertible, output ready);
endinterface
`default_nettype wire

/* hw/rtl/mie_datapath.sv */
`default_nettype none
module mie_datapath #(
    parameter int DATA_WIDTH = mie_pkg::DataWidthDefault
) (
    input  wire logic                              clk,
    input  wire logic [mie_pkg::FieldWidth-1:0]    value,
    input  wire logic [mie_pkg::FieldWidth-1:0]    modulus,
    input  wire mie_pkg::dp_cmd_t                  cmd,
    output mie_pkg::dp_status_t                    status,
    output logic [mie_pkg::FieldWidth-1:0]         inverse,
    output logic [mie_pkg::FieldWidth-1:0]         common_divisor,
    output logic                                   invertible
);
    localparam int OpWidth = DATA_WIDTH - 1;
    localparam int CntWidth = $clog2(DATA_WIDTH + 1);
    localparam int FW = mie_pkg::FieldWidth;

    logic [OpWidth-1:0]    mod_reg;
    logic [OpWidth-1:0]    rem_old_reg, rem_new_reg;
    logic [DATA_WIDTH-1:0] cof_old_reg, cof_new_reg;
    // Restoring divider: partial remainder and quotient shifted in.
    logic [OpWidth-1:0]    part_reg, quot_reg;
    logic [CntWidth-1:0]   cnt_reg;
    // Shift-add multiplier for quot * cof_new, wraps at DATA_WIDTH.
    logic [DATA_WIDTH-1:0] prod_reg, mcand_reg;
    logic [OpWidth-1:0]    mplier_reg;

    logic [OpWidth:0]      trial;
    logic [OpWidth-1:0]    dividend_bit_src;
    logic [OpWidth-1:0]    op_value, op_modulus;

    assign op_value = value[OpWidth-1:0];
    assign op_modulus = modulus[OpWidth-1:0];

    // One divider step: shift in the next dividend bit and try a subtract.
    assign dividend_bit_src = quot_reg;
    assign trial = {part_reg, dividend_bit_src[OpWidth-1]} - {1'b0, rem_new_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mod_reg <= op_modulus;
            rem_old_reg <= op_modulus;
            rem_new_reg <= op_value;
            cof_old_reg <= '0;
            cof_new_reg <= DATA_WIDTH'(1);
        end
        if (cmd.div_start)
        begin
            part_reg <= '0;
            quot_reg <= rem_old_reg;
            cnt_reg <= CntWidth'(OpWidth);
        end
        if (cmd.div_step)
        begin
            if (!trial[OpWidth])
            begin
                part_reg <= trial[OpWidth-1:0];
                quot_reg <= {quot_reg[OpWidth-2:0], 1'b1};
            end
            else
            begin
                part_reg <= {part_reg[OpWidth-2:0], quot_reg[OpWidth-1]};
                quot_reg <= {quot_reg[OpWidth-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg - CntWidth'(1);
            if (cnt_reg == CntWidth'(1))
            begin
                prod_reg <= '0;
                mcand_reg <= cof_new_reg;
            end
        end
        if (cmd.mul_step)
        begin
            if (mplier_reg[0])
                prod_reg <= prod_reg + mcand_reg;
            mcand_reg <= {mcand_reg[DATA_WIDTH-2:0], 1'b0};
            mplier_reg <= mplier_reg >> 1;
        end
        else if (cmd.div_step)
        begin
            mplier_reg <= trial[OpWidth] ? {quot_reg[OpWidth-2:0], 1'b0}
                                         : {quot_reg[OpWidth-2:0], 1'b1};
        end
        if (cmd.update)
        begin
            cof_old_reg <= cof_new_reg;
            cof_new_reg <= cof_old_reg - prod_reg;
            rem_old_reg <= rem_new_reg;
            rem_new_reg <= part_reg;
        end
        if (cmd.fix && cof_old_reg[DATA_WIDTH-1])
            cof_old_reg <= cof_old_reg + DATA_WIDTH'(mod_reg);
    end

    assign status.rem_zero = (rem_new_reg == '0);
    assign status.div_last = (cnt_reg == CntWidth'(1));

    assign inverse = FW'(cof_old_reg);
    assign common_divisor = FW'(rem_old_reg);
    assign invertible = (rem_old_reg == OpWidth'(1));
endmodule
`default_nettype wire

/* hw/rtl/mie_controller.sv */
`default_nettype none
module mie_controller #(
    parameter int DATA_WIDTH = mie_pkg::DataWidthDefault
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    input  wire mie_pkg::dp_status_t  status,
    output mie_pkg::dp_cmd_t          cmd
);
    localparam int CntWidth = $clog2(DATA_WIDTH);

    mie_pkg::state_t state_reg, state_next;
    logic [CntWidth-1:0] mcnt_reg, mcnt_next;

    // State and multiplier step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mie_pkg::ST_IDLE;
            mcnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mcnt_reg <= mcnt_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        mcnt_next = mcnt_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            mie_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = mie_pkg::ST_CHECK;
                end
            end
            mie_pkg::ST_CHECK:
            begin
                if (status.rem_zero)
                    state_next = mie_pkg::ST_FIX;
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next = mie_pkg::ST_DIV;
                end
            end
            mie_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    mcnt_next = CntWidth'(DATA_WIDTH - 2);
                    state_next = mie_pkg::ST_MUL;
                end
            end
            mie_pkg::ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                mcnt_next = mcnt_reg - CntWidth'(1);
                if (mcnt_reg == '0)
                    state_next = mie_pkg::ST_UPDATE;
            end
            mie_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = mie_pkg::ST_CHECK;
            end
            mie_pkg::ST_FIX:
            begin
                cmd.fix = 1'b1;
                state_next = mie_pkg::ST_DONE;
            end
            mie_pkg::ST_DONE:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = mie_pkg::ST_IDLE;
            end
            default:
                state_next = mie_pkg::ST_IDLE;
        endcase
    end

    // A result is only offered after the sign fix.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mie_pkg::ST_DONE && !$past(state_reg == mie_pkg::ST_DONE)
        |-> $past(state_reg == mie_pkg::ST_FIX))
        else $error("result offered without sign fix");
    // Division always hands over to the multiplier.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mie_pkg::ST_DIV && status.div_last |=> state_reg == mie_pkg::ST_MUL)
        else $error("division did not hand over to multiplier");
    // No new transaction while a result waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while result pending");
endmodule
`default_nettype wire

/* hw/rtl/modular_inverse_ext_euclid.sv */
`default_nettype none
// Channel   Direction  Payload
// in_ch     sink       value[62:0], modulus[62:0]
// out_ch    source     inverse[62:0], common_divisor[62:0], invertible
//
// One transaction at a time. After the load, each Euclid step passes
// through a check, a restoring division, a shift-add multiply and an
// update; the final check leads to the sign fix and the result. The result
// is held until taken; rst_n clears control state asynchronously.
module modular_inverse_ext_euclid #(
    parameter int DATA_WIDTH = mie_pkg::DataWidthDefault
) (
    input wire logic  clk,
    input wire logic  rst_n,
    mie_in_if.sink    in_ch,
    mie_out_if.source out_ch
);
    mie_pkg::dp_cmd_t    cmd;
    mie_pkg::dp_status_t status;

    mie_controller #(.DATA_WIDTH(DATA_WIDTH)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .status(status), .cmd(cmd)
    );

    mie_datapath #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
        .clk(clk),
        .value(in_ch.value), .modulus(in_ch.modulus),
        .cmd(cmd), .status(status),
        .inverse(out_ch.inverse), .common_divisor(out_ch.common_divisor),
        .invertible(out_ch.invertible)
    );
endmodule
`default_nettype wire
